>>> rtl/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
package bba_pkg;

  localparam int OFF_W  = 9;   // width of a unit offset field
  localparam int SIZE_W = 10;  // width of the request size field
  localparam int PO_W   = 4;   // width of the pool order register
  localparam int GORD_W = 4;   // width of the granted order field
  localparam int ORD_W  = 5;   // internal order width, holds any order up to 16

  typedef enum logic [1:0] {
    ND_FREE  = 2'd0,
    ND_SPLIT = 2'd1,
    ND_ALLOC = 2'd2
  } node_st_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef struct packed {
    logic [GORD_W-1:0] order;
    logic [OFF_W-1:0]  offset;
    status_t           status;
  } resp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_EV,
    S_A_UP,
    S_A_SPL,
    S_A_SPR,
    S_A_SET,
    S_F_RD,
    S_F_EV,
    S_F_MRD,
    S_F_MEV,
    S_RESP
  } state_t;

endpackage

>>> rtl/buddy_block_allocator_top.sv
// Top level of the buddy block allocator: config register, tree memory, result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in_     | sink      | in_tvalid / in_tready   | tuser: action; tdata: size, offset
//  out_    | source    | out_tvalid / out_tready | tdata: status, granted offset and order
//  cfg_    | sink      | cfg_valid / cfg_ready   | cfg_data: pool_order
//
// One transaction at a time: the controller takes it while idle, reads and evaluates one node
// per tree level, writes the split node and its right child per split level, reads the buddy
// and merges per merge level, marks an allocated block and then offers the result; an early
// rejection goes straight to the result, and a backtracking allocate adds a climb per level.
// After reset and after every pool_order write a clearing pass sweeps the whole node memory
// to free, with in_tready low; a result waits in the output register.
module buddy_block_allocator_top #(
  parameter int MAX_ORDER = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // [0] action
  input  logic [23:0] in_tdata,   // [9:0] request_size, [18:10] block_offset, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] status, [10:2] granted_offset, [14:11] granted_order
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data    // [3:0] pool_order
);

  localparam int NODE_W = MAX_ORDER + 1;
  localparam logic [bba_pkg::ORD_W-1:0] MAX_O = bba_pkg::ORD_W'(MAX_ORDER);

  logic [bba_pkg::PO_W-1:0]  pool_order_r;
  logic [bba_pkg::ORD_W-1:0] po_eff, po_ext;
  logic cfg_wr;

  logic resp_valid, resp_ready;
  bba_pkg::resp_t resp;

  logic out_valid_r;
  bba_pkg::resp_t out_data_r;

  logic ram_we, ram_re;
  logic [NODE_W-1:0] ram_waddr, ram_raddr;
  logic [1:0] ram_wdata, ram_rdata;

  // config is always accepted; a write also restarts the clearing pass
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_order_r <= bba_pkg::PO_W'(9);
    end else if (cfg_wr) begin
      pool_order_r <= cfg_data;
    end
  end

  // saturate the pool order to what the tree holds
  assign po_ext = bba_pkg::ORD_W'(pool_order_r);
  assign po_eff = (po_ext > MAX_O) ? MAX_O : po_ext;

  bba_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .po         (po_eff),
    .cfg_wr     (cfg_wr),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_tuser[0]),
    .in_size    (in_tdata[9:0]),
    .in_off     (in_tdata[18:10]),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  bba_ram #(.WIDTH(2), .DEPTH(1 << NODE_W)) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: load when empty or being drained this cycle
  assign resp_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_ready) begin
      out_valid_r <= resp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_ready && resp_valid) begin
      out_data_r <= resp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

endmodule

>>> rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/bba_ctrl.sv
// Sequencer that walks the node tree in memory for allocate and free transactions.
module bba_ctrl #(
  parameter int MAX_ORDER = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [bba_pkg::ORD_W-1:0] po,
  input  logic                      cfg_wr,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [bba_pkg::SIZE_W-1:0] in_size,
  input  logic [bba_pkg::OFF_W-1:0] in_off,
  output logic                      resp_valid,
  input  logic                      resp_ready,
  output bba_pkg::resp_t            resp,
  output logic                      ram_we,
  output logic [MAX_ORDER:0]        ram_waddr,
  output logic [1:0]                ram_wdata,
  output logic                      ram_re,
  output logic [MAX_ORDER:0]        ram_raddr,
  input  logic [1:0]                ram_rdata
);

  localparam int NODE_W = MAX_ORDER + 1;
  localparam int ADDR_W = MAX_ORDER;
  localparam logic [bba_pkg::ORD_W-1:0] MAX_O = bba_pkg::ORD_W'(MAX_ORDER);

  bba_pkg::state_t state_r, state_nxt;
  logic [NODE_W-1:0] n_r, n_nxt, clr_r, clr_nxt;
  logic [bba_pkg::ORD_W-1:0] o_r, o_nxt, k_r, k_nxt;
  logic [ADDR_W-1:0] off_r, off_nxt;
  bba_pkg::resp_t res_r, res_nxt;

  logic [NODE_W-1:0] root, n_left, n_right, bstart_full, off_sh;
  logic [ADDR_W-1:0] bstart;
  logic [bba_pkg::ORD_W-1:0] in_k, o_dec;
  logic [bba_pkg::SIZE_W-1:0] size_m1;
  logic [bba_pkg::OFF_W-1:0] off_hi;
  logic accept;

  assign root    = NODE_W'(1) << (MAX_O - po);
  assign n_left  = {n_r[NODE_W-2:0], 1'b0};
  assign n_right = {n_r[NODE_W-2:0], 1'b1};
  assign o_dec   = o_r - 1'b1;
  assign bstart_full = (n_r ^ (NODE_W'(1) << (MAX_O - o_r))) << o_r;
  assign bstart  = bstart_full[ADDR_W-1:0];
  assign off_sh  = NODE_W'(off_r) >> o_dec;
  assign off_hi  = in_off >> po;
  assign accept  = in_valid && in_ready;

  // round the size up to the next power of two; zero counts as one
  always_comb begin
    size_m1 = (in_size == '0) ? '0 : in_size - 1'b1;
    in_k = '0;
    for (int i = 0; i < bba_pkg::SIZE_W; i++) begin
      if (size_m1[i]) begin
        in_k = bba_pkg::ORD_W'(i + 1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    o_nxt     = o_r;
    k_nxt     = k_r;
    off_nxt   = off_r;
    res_nxt   = res_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      bba_pkg::S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          n_nxt   = root;
          o_nxt   = po;
          k_nxt   = in_k;
          off_nxt = ADDR_W'(in_off);
          if (!in_action) begin
            if (in_k > po) begin
              res_nxt.status = bba_pkg::ST_OOM;
              state_nxt = bba_pkg::S_RESP;
            end else begin
              state_nxt = bba_pkg::S_A_RD;
            end
          end else if (off_hi != '0) begin
            res_nxt.status = bba_pkg::ST_BADFREE;
            state_nxt = bba_pkg::S_RESP;
          end else begin
            state_nxt = bba_pkg::S_F_RD;
          end
        end
      end
      bba_pkg::S_A_RD: state_nxt = bba_pkg::S_A_EV;
      bba_pkg::S_A_EV: begin
        if (ram_rdata == bba_pkg::ND_FREE && o_r >= k_r) begin
          state_nxt = (o_r > k_r) ? bba_pkg::S_A_SPL : bba_pkg::S_A_SET;
        end else if (ram_rdata == bba_pkg::ND_SPLIT && o_r > k_r) begin
          n_nxt = n_left;
          o_nxt = o_dec;
          state_nxt = bba_pkg::S_A_RD;
        end else begin
          state_nxt = bba_pkg::S_A_UP;
        end
      end
      bba_pkg::S_A_UP: begin
        // backtrack: out of memory at the root, right sibling if we are a left child, else climb
        if (n_r == root) begin
          res_nxt.status = bba_pkg::ST_OOM;
          state_nxt = bba_pkg::S_RESP;
        end else if (!n_r[0]) begin
          n_nxt = n_r + 1'b1;
          state_nxt = bba_pkg::S_A_RD;
        end else begin
          n_nxt = n_r >> 1;
          o_nxt = o_r + 1'b1;
        end
      end
      bba_pkg::S_A_SPL: state_nxt = bba_pkg::S_A_SPR;
      bba_pkg::S_A_SPR: begin
        n_nxt = n_left;
        o_nxt = o_dec;
        state_nxt = (o_dec > k_r) ? bba_pkg::S_A_SPL : bba_pkg::S_A_SET;
      end
      bba_pkg::S_A_SET: begin
        res_nxt.status = bba_pkg::ST_OK;
        res_nxt.offset = bba_pkg::OFF_W'(bstart);
        res_nxt.order  = bba_pkg::GORD_W'(o_r);
        state_nxt = bba_pkg::S_RESP;
      end
      bba_pkg::S_F_RD: state_nxt = bba_pkg::S_F_EV;
      bba_pkg::S_F_EV: begin
        if (ram_rdata == bba_pkg::ND_ALLOC) begin
          if (bstart != off_r) begin
            res_nxt.status = bba_pkg::ST_BADFREE;
            state_nxt = bba_pkg::S_RESP;
          end else begin
            res_nxt.status = bba_pkg::ST_OK;
            res_nxt.offset = bba_pkg::OFF_W'(off_r);
            res_nxt.order  = bba_pkg::GORD_W'(o_r);
            state_nxt = (n_r == root) ? bba_pkg::S_RESP : bba_pkg::S_F_MRD;
          end
        end else if (ram_rdata == bba_pkg::ND_SPLIT && o_r != '0) begin
          o_nxt = o_dec;
          n_nxt = {n_r[NODE_W-2:0], off_sh[0]};
          state_nxt = bba_pkg::S_F_RD;
        end else begin
          res_nxt.status = bba_pkg::ST_BADFREE;
          state_nxt = bba_pkg::S_RESP;
        end
      end
      bba_pkg::S_F_MRD: state_nxt = bba_pkg::S_F_MEV;
      bba_pkg::S_F_MEV: begin
        if (ram_rdata == bba_pkg::ND_FREE) begin
          n_nxt = n_r >> 1;
          state_nxt = ((n_r >> 1) == root) ? bba_pkg::S_RESP : bba_pkg::S_F_MRD;
        end else begin
          state_nxt = bba_pkg::S_RESP;
        end
      end
      bba_pkg::S_RESP: begin
        if (resp_ready) begin
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      default: state_nxt = bba_pkg::S_CLEAR;
    endcase
    if (cfg_wr) begin
      state_nxt = bba_pkg::S_CLEAR;
      clr_nxt   = '0;
    end
  end

  always_comb begin
    in_ready   = (state_r == bba_pkg::S_IDLE);
    resp_valid = (state_r == bba_pkg::S_RESP);
    ram_we     = 1'b0;
    ram_waddr  = n_r;
    ram_wdata  = bba_pkg::ND_FREE;
    ram_re     = 1'b0;
    ram_raddr  = n_r;
    unique case (state_r)
      bba_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      bba_pkg::S_A_RD, bba_pkg::S_F_RD: ram_re = 1'b1;
      bba_pkg::S_F_MRD: begin
        ram_re    = 1'b1;
        ram_raddr = {n_r[NODE_W-1:1], ~n_r[0]};
      end
      bba_pkg::S_A_SPL: begin
        ram_we    = 1'b1;
        ram_wdata = bba_pkg::ND_SPLIT;
      end
      bba_pkg::S_A_SPR: begin
        ram_we    = 1'b1;
        ram_waddr = n_right;
      end
      bba_pkg::S_A_SET: begin
        ram_we    = 1'b1;
        ram_wdata = bba_pkg::ND_ALLOC;
      end
      bba_pkg::S_F_EV: begin
        ram_we = (ram_rdata == bba_pkg::ND_ALLOC) && (bstart == off_r);
      end
      bba_pkg::S_F_MEV: begin
        ram_we    = (ram_rdata == bba_pkg::ND_FREE);
        ram_waddr = n_r >> 1;
      end
      default: ;
    endcase
  end

  assign resp = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    o_r   <= o_nxt;
    k_r   <= k_nxt;
    off_r <= off_nxt;
    res_r <= res_nxt;
  end

endmodule

>>> test/buddy_block_allocator_top_test.sv
// Self-checking testbench for the buddy block allocator: streams allocate and free requests.
`timescale 1ns / 1ps

module buddy_block_allocator_top_test;

  localparam int MAX_ORD   = 9;
  localparam int NODE_CNT  = 1 << (MAX_ORD + 1);
  localparam int ACT_ALLOC = 0;
  localparam int ACT_FREE  = 1;

  typedef struct packed {
    logic [8:0] offset;
    logic [9:0] size;
    logic       action;
  } request_t;

  typedef struct {
    bba_pkg::status_t status;
    logic [8:0]       offset;
    logic [3:0]       order;
  } grant_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [0:0]  in_tuser;   // [0] action
  logic [23:0] in_tdata;   // [9:0] request_size, [18:10] block_offset, rest zero
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [1:0] status, [10:2] granted_offset, [14:11] granted_order
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;

  buddy_block_allocator_top #(.MAX_ORDER(MAX_ORD)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state: a private copy of the node tree and the pool order.
  bba_pkg::node_st_t tree_nodes [NODE_CNT];
  logic [3:0]        pool_ord;

  request_t pending_reqs [$];
  grant_t   expected_grants [$];
  int       error_count;
  int       send_burst;
  int       send_gap;
  int       stall_phase;
  bit       hold_sender;

  // Live allocations, used to steer frees to real blocks.
  logic [8:0] live_offsets [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("buddy_block_allocator_top verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic int eff_pool();
    return (pool_ord > MAX_ORD) ? MAX_ORD : int'(pool_ord);
  endfunction

  function automatic int node_base(int n, int o);
    return (n - (1 << (MAX_ORD - o))) << o;
  endfunction

  // Lowest-address free node of order >= k below n; 0 when nothing fits.
  function automatic int search_free(int n, int o, int k, ref int found);
    int r;
    if (tree_nodes[n] == bba_pkg::ND_FREE) begin
      if (o >= k) begin
        found = o;
        return n;
      end
      return 0;
    end
    if (tree_nodes[n] == bba_pkg::ND_SPLIT && o > k && o > 0) begin
      r = search_free(2 * n, o - 1, k, found);
      if (r != 0) return r;
      return search_free(2 * n + 1, o - 1, k, found);
    end
    return 0;
  endfunction

  function automatic void clear_tree();
    foreach (tree_nodes[i]) tree_nodes[i] = bba_pkg::ND_FREE;
  endfunction

  // Apply one request to the tree and return the grant it should produce.
  function automatic grant_t predict_grant(request_t req);
    grant_t g;
    int po, root, n, o, k, sz, off, idx;
    bit done;
    po   = eff_pool();
    root = 1 << (MAX_ORD - po);
    g.status = bba_pkg::ST_OK;
    g.offset = '0;
    g.order  = '0;
    if (req.action == 1'(ACT_ALLOC)) begin
      sz = (req.size == 0) ? 1 : int'(req.size);
      k  = 0;
      while ((1 << k) < sz) k++;
      if (k > po) begin
        g.status = bba_pkg::ST_OOM;
        return g;
      end
      o = 0;
      n = search_free(root, po, k, o);
      if (n == 0) begin
        g.status = bba_pkg::ST_OOM;
        return g;
      end
      while (o > k) begin
        tree_nodes[n]         = bba_pkg::ND_SPLIT;
        tree_nodes[2 * n]     = bba_pkg::ND_FREE;
        tree_nodes[2 * n + 1] = bba_pkg::ND_FREE;
        n = 2 * n;
        o--;
      end
      tree_nodes[n] = bba_pkg::ND_ALLOC;
      g.offset = 9'(node_base(n, o));
      g.order  = 4'(o);
      live_offsets.push_back(g.offset);
      return g;
    end
    off = int'(req.offset);
    if ((off >> po) != 0) begin
      g.status = bba_pkg::ST_BADFREE;
      return g;
    end
    n = root;
    o = po;
    done = 0;
    while (!done) begin
      if (tree_nodes[n] == bba_pkg::ND_ALLOC) begin
        if (node_base(n, o) != off) begin
          g.status = bba_pkg::ST_BADFREE;
          return g;
        end
        done = 1;
      end else if (tree_nodes[n] == bba_pkg::ND_SPLIT && o > 0) begin
        o--;
        n = 2 * n + ((off >> o) & 1);
      end else begin
        g.status = bba_pkg::ST_BADFREE;
        return g;
      end
    end
    g.offset = 9'(off);
    g.order  = 4'(o);
    tree_nodes[n] = bba_pkg::ND_FREE;
    while (n != root && tree_nodes[n ^ 1] == bba_pkg::ND_FREE) begin
      n = n >> 1;
      tree_nodes[n] = bba_pkg::ND_FREE;
    end
    idx = -1;
    foreach (live_offsets[i]) if (int'(live_offsets[i]) == off) idx = i;
    if (idx >= 0) live_offsets.delete(idx);
    return g;
  endfunction

  // Driver: bursts of back-to-back transactions separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_burst <= 0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_grants.push_back(predict_grant(pending_reqs.pop_front()));
      end
      if (in_tvalid && !in_tready) begin
        // hold the current transaction
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_sender) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_reqs[0].action;
        in_tdata  <= {5'b0, pending_reqs[0].offset, pending_reqs[0].size};
        if (send_burst <= 1) begin
          send_burst <= $urandom_range(1, 12);
          send_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          send_burst <= send_burst - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transaction against the oldest expectation.
  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected result", int'(out_tdata), -1);
        end else begin
          want = expected_grants.pop_front();
          if (out_tdata[1:0] != want.status)
            report_mismatch("status", int'(out_tdata[1:0]), int'(want.status));
          if (out_tdata[10:2] != want.offset)
            report_mismatch("granted_offset", int'(out_tdata[10:2]), int'(want.offset));
          if (out_tdata[14:11] != want.order)
            report_mismatch("granted_order", int'(out_tdata[14:11]), int'(want.order));
        end
      end
      // Stall pattern: alternate stretches of always-ready and random stalls.
      stall_phase <= (stall_phase + 1) % 400;
      out_tready <= (stall_phase < 150) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  function automatic request_t make_alloc(int sz);
    request_t r;
    r.action = 1'(ACT_ALLOC);
    r.size   = 10'(sz);
    r.offset = 9'($urandom_range(0, 511));
    return r;
  endfunction

  function automatic request_t make_free(int off);
    request_t r;
    r.action = 1'(ACT_FREE);
    r.size   = 10'($urandom_range(0, 1023));
    r.offset = 9'(off);
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_grants.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_pool_order(input logic [3:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pool_ord = value;
    clear_tree();
    live_offsets.delete();
  endtask

  // Random requests: mostly allocs and frees of live blocks, some stray frees.
  task automatic queue_random(input int count, input int max_sz);
    int pick, sel;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        pending_reqs.push_back(make_alloc(($urandom_range(0, 9) == 0) ?
                               $urandom_range(0, 1023) : $urandom_range(0, max_sz)));
      end else if (pick < 85 && live_offsets.size() > 0) begin
        // free a block that the predictor last saw live: settle the queue first
        while (pending_reqs.size() > 0 || in_tvalid) @(posedge clk);
        if (live_offsets.size() > 0) begin
          sel = $urandom_range(0, live_offsets.size() - 1);
          pending_reqs.push_back(make_free(int'(live_offsets[sel])));
        end
      end else begin
        pending_reqs.push_back(make_free($urandom_range(0, 511)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    error_count = 0;
    hold_sender = 0;
    pool_ord = 4'd9;
    clear_tree();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero size, full pool, oversize, bad frees, split and merge.
    pending_reqs.push_back(make_alloc(0));
    pending_reqs.push_back(make_alloc(1023));
    pending_reqs.push_back(make_alloc(3));
    pending_reqs.push_back(make_alloc(512));
    pending_reqs.push_back(make_free(1));
    pending_reqs.push_back(make_free(2));
    pending_reqs.push_back(make_free(4));
    pending_reqs.push_back(make_free(4));
    pending_reqs.push_back(make_free(0));
    pending_reqs.push_back(make_alloc(512));
    pending_reqs.push_back(make_alloc(1));
    pending_reqs.push_back(make_free(511));
    pending_reqs.push_back(make_free(0));
    pending_reqs.push_back(make_free(0));
    pending_reqs.push_back(make_alloc(256));
    pending_reqs.push_back(make_alloc(256));
    pending_reqs.push_back(make_alloc(1));
    pending_reqs.push_back(make_free(256));
    wait_drained();

    // Tiny pool: order zero, then order above the maximum (saturates).
    write_pool_order(4'd0);
    pending_reqs.push_back(make_alloc(1));
    pending_reqs.push_back(make_alloc(1));
    pending_reqs.push_back(make_alloc(2));
    pending_reqs.push_back(make_free(1));
    pending_reqs.push_back(make_free(0));
    queue_random(60, 2);
    wait_drained();

    write_pool_order(4'd15);
    queue_random(400, 64);
    // hold the sender until every result has been seen
    while (pending_reqs.size() > 0 || in_tvalid) @(posedge clk);
    hold_sender = 1;
    while (expected_grants.size() > 0) @(posedge clk);
    hold_sender = 0;
    queue_random(200, 512);
    wait_drained();

    write_pool_order(4'd3);
    queue_random(300, 10);
    wait_drained();

    write_pool_order(4'd6);
    queue_random(300, 70);
    wait_drained();

    write_pool_order(4'd9);
    queue_random(340, 40);
    wait_drained();

    if (error_count == 0)
      $display("buddy_block_allocator_top verification clean");
    else
      $display("buddy_block_allocator_top verification failed");
    $finish;
  end

endmodule
